>>> rtl/rfz_pkg.sv
package rfz_pkg;

  // Widths of the scaled vector and of the plane sums
  localparam int RW = 42;  // r = axis * length, Q.32, signed
  localparam int SW = 43;  // r0 +/- r1, signed
  localparam int MW = 42;  // |r|, unsigned
  localparam int AW = 44;  // |r0| + |r1| + |r2|, unsigned
  localparam int PW = 60;  // weighted plane sums, Q.48, signed
  localparam int BW = 33;  // bounds on |r| in Q.32

  // Configuration register indexes
  localparam logic CFG_CLASS = 1'b0;
  localparam logic CFG_ORDER = 1'b1;

  // Symmetry classes
  typedef enum logic [2:0] {
    CLS_ANORTHIC = 3'd0,
    CLS_CYCLIC   = 3'd1,
    CLS_DIHEDRAL = 3'd2,
    CLS_TETRA    = 3'd3,
    CLS_OCTA     = 3'd4
  } sym_class_e;

  // Main axis orders in use
  localparam logic [2:0] ORD_2 = 3'd2;
  localparam logic [2:0] ORD_3 = 3'd3;
  localparam logic [2:0] ORD_4 = 3'd4;
  localparam logic [2:0] ORD_6 = 3'd6;

  // Q.16 weights, sign-extended to the plane width
  localparam logic signed [PW-1:0] K_SQRT3_2 = PW'(56756);
  localparam logic signed [PW-1:0] K_SQRT2_2 = PW'(46341);

  // Limits: 1.0 in Q.32 and Q.48, tan(pi/8) in Q.32
  localparam logic [BW-1:0]        LIM_UNIT32 = BW'(64'd1 << 32);
  localparam logic [BW-1:0]        LIM_TAN8   = BW'(64'd27146 << 16);
  localparam logic signed [PW-1:0] LIM_UNIT48 = PW'(64'sd1 <<< 48);

  typedef struct packed {
    logic [2:0] sym_class;
    logic [2:0] axis_order;
  } cfg_t;

  typedef struct packed {
    logic signed [RW-1:0] r0;
    logic signed [RW-1:0] r1;
    logic signed [RW-1:0] r2;
    logic                 inf;
    logic                 axz_zero;
  } scaled_t;

  typedef struct packed {
    logic inf;
    logic axz_zero;
    logic z_ok;
    logic u0;
    logic u1;
    logic cube_ok;
    logic octa_ok;
    logic p3a;
    logic p3b;
    logic p4a;
    logic p4b;
    logic p6a;
    logic p6b;
  } flags_t;

  // tan(pi/2n) in Q.32; zero for orders not in use
  function automatic logic [BW-1:0] half_angle_bound(input logic [2:0] n);
    logic [BW-1:0] b;
    case (n)
      ORD_2:   b = BW'(64'd65536 << 16);
      ORD_3:   b = BW'(64'd37837 << 16);
      ORD_4:   b = BW'(64'd27146 << 16);
      ORD_6:   b = BW'(64'd17560 << 16);
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic order_known(input logic [2:0] n);
    return (n == ORD_2) || (n == ORD_3) || (n == ORD_4) || (n == ORD_6);
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [RW-1:0] v);
    return v[RW-1] ? MW'(-v) : MW'(v);
  endfunction

  // -1.0 <= x <= 1.0 in Q.48
  function automatic logic within_unit48(input logic signed [PW-1:0] x);
    return (x <= LIM_UNIT48) && (x >= -LIM_UNIT48);
  endfunction

endpackage

>>> rtl/rfz_scale.sv
module rfz_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [17:0]     axis_x_i,
  input  logic signed [17:0]     axis_y_i,
  input  logic signed [17:0]     axis_z_i,
  input  logic [23:0]            vector_length_i,
  input  logic                   length_infinite_i,
  output logic                   valid_o,
  output rfz_pkg::scaled_t       scaled_o
);
  import rfz_pkg::*;

  logic signed [24:0] len_s;
  logic signed [RW:0] px, py, pz;
  scaled_t            sc_d, sc_q;
  logic               valid_q;

  // r_i = axis_i * length, exact in Q.32
  assign len_s = signed'({1'b0, vector_length_i});
  assign px    = (RW+1)'(axis_x_i) * (RW+1)'(len_s);
  assign py    = (RW+1)'(axis_y_i) * (RW+1)'(len_s);
  assign pz    = (RW+1)'(axis_z_i) * (RW+1)'(len_s);

  always_comb begin
    sc_d.r0       = px[RW-1:0];
    sc_d.r1       = py[RW-1:0];
    sc_d.r2       = pz[RW-1:0];
    sc_d.inf      = length_infinite_i;
    sc_d.axz_zero = (axis_z_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q <= sc_d;
    end
  end

  assign valid_o  = valid_q;
  assign scaled_o = sc_q;

endmodule

>>> rtl/rfz_plane.sv
module rfz_plane (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rfz_pkg::scaled_t scaled_i,
  input  logic [2:0]       axis_order_i,
  output logic             valid_o,
  output rfz_pkg::flags_t  flags_o
);
  import rfz_pkg::*;

  // ---- stage A: magnitudes, sum/difference, simple bounds
  logic signed [RW-1:0] r0_q, r1_q;
  logic signed [SW-1:0] s_q, d_q;
  logic [MW-1:0]        m0_d, m1_d, m2_d;
  logic [MW-1:0]        m0_q, m1_q, m2_q;
  logic                 a_inf_q, a_axz_q, a_zok_q, a_u0_q, a_u1_q, a_octa_q;
  logic                 a_valid_q;

  assign m0_d = mag(scaled_i.r0);
  assign m1_d = mag(scaled_i.r1);
  assign m2_d = mag(scaled_i.r2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q     <= scaled_i.r0;
      r1_q     <= scaled_i.r1;
      s_q      <= SW'(scaled_i.r0) + SW'(scaled_i.r1);
      d_q      <= SW'(scaled_i.r0) - SW'(scaled_i.r1);
      m0_q     <= m0_d;
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      a_inf_q  <= scaled_i.inf;
      a_axz_q  <= scaled_i.axz_zero;
      a_zok_q  <= (m2_d <= MW'(half_angle_bound(axis_order_i)));
      a_u0_q   <= (m0_d <= MW'(LIM_UNIT32));
      a_u1_q   <= (m1_d <= MW'(LIM_UNIT32));
      a_octa_q <= (m0_d <= MW'(LIM_TAN8)) && (m1_d <= MW'(LIM_TAN8)) &&
                  (m2_d <= MW'(LIM_TAN8));
    end
  end

  // ---- stage B: constant products, cube sum
  logic signed [PW-1:0] k3r0_q, k3r1_q, k2s_q, k2d_q, hr0_q, hr1_q;
  logic [AW-1:0]        msum;
  logic                 b_inf_q, b_axz_q, b_zok_q, b_u0_q, b_u1_q, b_octa_q, b_cube_q;
  logic                 b_valid_q;

  assign msum = AW'(m0_q) + AW'(m1_q) + AW'(m2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k3r0_q   <= PW'(r0_q) * K_SQRT3_2;
      k3r1_q   <= PW'(r1_q) * K_SQRT3_2;
      k2s_q    <= PW'(s_q) * K_SQRT2_2;
      k2d_q    <= PW'(d_q) * K_SQRT2_2;
      hr0_q    <= PW'(r0_q) <<< 15;
      hr1_q    <= PW'(r1_q) <<< 15;
      b_cube_q <= (msum <= AW'(LIM_UNIT32));
      b_inf_q  <= a_inf_q;
      b_axz_q  <= a_axz_q;
      b_zok_q  <= a_zok_q;
      b_u0_q   <= a_u0_q;
      b_u1_q   <= a_u1_q;
      b_octa_q <= a_octa_q;
    end
  end

  // ---- stage C: plane sums against 1.0 in Q.48
  flags_t fl_d, fl_q;
  logic   c_valid_q;

  always_comb begin
    fl_d.inf      = b_inf_q;
    fl_d.axz_zero = b_axz_q;
    fl_d.z_ok     = b_zok_q;
    fl_d.u0       = b_u0_q;
    fl_d.u1       = b_u1_q;
    fl_d.cube_ok  = b_cube_q;
    fl_d.octa_ok  = b_octa_q;
    fl_d.p3a      = within_unit48(k3r0_q + hr1_q);
    fl_d.p3b      = within_unit48(k3r0_q - hr1_q);
    fl_d.p4a      = within_unit48(k2s_q);
    fl_d.p4b      = within_unit48(k2d_q);
    fl_d.p6a      = within_unit48(hr0_q + k3r1_q);
    fl_d.p6b      = within_unit48(hr0_q - k3r1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q <= fl_d;
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  assign valid_o = c_valid_q;
  assign flags_o = fl_q;

endmodule

>>> rtl/rfz_decide.sv
module rfz_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rfz_pkg::flags_t flags_i,
  input  rfz_pkg::cfg_t   cfg_i,
  output logic            valid_o,
  output logic            inside_o
);
  import rfz_pkg::*;

  logic dih_shape, known, inside_d, inside_q, valid_q;

  assign known = order_known(cfg_i.axis_order);

  // in-plane test of the dihedral zone for each order
  always_comb begin
    case (cfg_i.axis_order)
      ORD_2:   dih_shape = flags_i.u0 && flags_i.u1;
      ORD_3:   dih_shape = flags_i.p3a && flags_i.p3b && flags_i.u1;
      ORD_4:   dih_shape = flags_i.u0 && flags_i.u1 && flags_i.p4a && flags_i.p4b;
      ORD_6:   dih_shape = flags_i.p6a && flags_i.p6b && flags_i.p3a && flags_i.p3b &&
                           flags_i.u1 && flags_i.u0;
      default: dih_shape = 1'b0;
    endcase
  end

  // class selection
  always_comb begin
    case (cfg_i.sym_class)
      CLS_ANORTHIC: inside_d = 1'b1;
      CLS_CYCLIC:   inside_d = known && (flags_i.inf ? flags_i.axz_zero : flags_i.z_ok);
      CLS_DIHEDRAL: inside_d = !flags_i.inf && known && flags_i.z_ok && dih_shape;
      CLS_TETRA:    inside_d = !flags_i.inf && flags_i.cube_ok;
      CLS_OCTA:     inside_d = !flags_i.inf && flags_i.cube_ok && flags_i.octa_ok;
      default:      inside_d = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_q <= inside_d;
    end
  end

  assign valid_o  = valid_q;
  assign inside_o = inside_q;

endmodule

>>> rtl/rodrigues_fundamental_zone_test.sv
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_stall_o    axis_x/y/z, vector_length, length_infinite
// out      output     out_valid_o / out_stall_i  inside_zone
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One word per cycle while out is not stalled; a taken word passes the registers
// for multiply, magnitudes, constant products, plane compares and class select in turn.
// Reset clears all valid bits and sets the class to anorthic, order 2.
// A stall on out holds every stage at once; in_stall_o follows it only
// while the output register holds a word.
module rodrigues_fundamental_zone_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [17:0] axis_x_i,
  input  logic signed [17:0] axis_y_i,
  input  logic signed [17:0] axis_z_i,
  input  logic [23:0]        vector_length_i,
  input  logic               length_infinite_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               inside_zone_o
);
  import rfz_pkg::*;

  cfg_t    cfg_q;
  logic    adv;
  logic    sc_valid, fl_valid;
  scaled_t scaled;
  flags_t  flags;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sym_class  <= CLS_ANORTHIC;
      cfg_q.axis_order <= ORD_2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLASS: cfg_q.sym_class  <= cfg_wdata_i;
        CFG_ORDER: cfg_q.axis_order <= cfg_wdata_i;
        default:   cfg_q <= cfg_q;
      endcase
    end
  end

  // whole pipe moves unless a held result is stalled
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  rfz_scale u_scale (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (adv),
    .valid_i           (in_valid_i),
    .axis_x_i          (axis_x_i),
    .axis_y_i          (axis_y_i),
    .axis_z_i          (axis_z_i),
    .vector_length_i   (vector_length_i),
    .length_infinite_i (length_infinite_i),
    .valid_o           (sc_valid),
    .scaled_o          (scaled)
  );

  rfz_plane u_plane (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (sc_valid),
    .scaled_i     (scaled),
    .axis_order_i (cfg_q.axis_order),
    .valid_o      (fl_valid),
    .flags_o      (flags)
  );

  rfz_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (fl_valid),
    .flags_i  (flags),
    .cfg_i    (cfg_q),
    .valid_o  (out_valid_o),
    .inside_o (inside_zone_o)
  );

endmodule

>>> test/rodrigues_fundamental_zone_test_test.sv
`timescale 1ns / 1ps

module rodrigues_fundamental_zone_test_test;
  import rfz_pkg::*;

  // Codes without a package name
  localparam logic [2:0] CLS_SPARE5 = 3'd5;
  localparam logic [2:0] CLS_SPARE7 = 3'd7;
  localparam logic [2:0] ORD_SPARE0 = 3'd0;
  localparam logic [2:0] ORD_SPARE5 = 3'd5;
  localparam logic [2:0] ORD_SPARE7 = 3'd7;

  // Q.16 weights and limits, with 1.0 also in Q.32 and Q.48
  localparam longint UNIT_Q16    = 65536;
  localparam longint HALF_Q16    = 32768;
  localparam longint ROOT3_HALF  = 56756;
  localparam longint ROOT2_HALF  = 46341;
  localparam longint TAN_PI_4    = 65536;
  localparam longint TAN_PI_6    = 37837;
  localparam longint TAN_PI_8    = 27146;
  localparam longint TAN_PI_12   = 17560;
  localparam longint UNIT_Q32    = longint'(1) <<< 32;
  localparam longint UNIT_Q48    = longint'(1) <<< 48;

  // Input field extremes
  localparam logic signed [17:0] AXIS_MIN_CODE = 18'sh20000;
  localparam logic signed [17:0] AXIS_MAX_CODE = 18'sh1FFFF;
  localparam logic signed [17:0] AXIS_ONE      = 18'sd65536;
  localparam logic [23:0]        LENGTH_MAX    = 24'hFFFFFF;
  localparam logic [23:0]        LENGTH_ONE    = 24'd65536;

  // Run control
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 80;

  typedef struct packed {
    logic [2:0]         cls;
    logic [2:0]         ord;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic [23:0]        len;
    logic               infinite;
    logic               typed_in;
    logic               typed_inside;
  } zone_case_t;

  logic               clk_i;
  logic               rst_ni            = 1'b0;
  logic               cfg_we_i          = 1'b0;
  logic               cfg_idx_i         = CFG_CLASS;
  logic [2:0]         cfg_wdata_i       = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic signed [17:0] axis_x_i          = '0;
  logic signed [17:0] axis_y_i          = '0;
  logic signed [17:0] axis_z_i          = '0;
  logic [23:0]        vector_length_i   = '0;
  logic               length_infinite_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic               inside_zone_o;

  logic [2:0] cur_cls = CLS_ANORTHIC;
  logic [2:0] cur_ord = ORD_2;
  zone_case_t rows[$];
  bit         inside_expected_q[$];
  bit         inside_want;
  int         fail_count  = 0;
  int         words_sent  = 0;
  int         burst_left  = 0;
  int         idle_cycles = 0;
  int         stall_mode  = 0;
  int         mode_left   = 0;
  int         hold_left   = 0;
  bit         hold_done   = 1'b0;

  rodrigues_fundamental_zone_test i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .axis_x_i          (axis_x_i),
    .axis_y_i          (axis_y_i),
    .axis_z_i          (axis_z_i),
    .vector_length_i   (vector_length_i),
    .length_infinite_i (length_infinite_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .inside_zone_o     (inside_zone_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // append one row to the directed table
  function automatic void add_row(input zone_case_t r);
    rows = {rows, r};
  endfunction

  // append one expected word to the scoreboard
  function automatic void queue_expected(input bit v);
    inside_expected_q = {inside_expected_q, v};
  endfunction

  // ---------------------------------------------------------------------------
  // Zone predictor
  // ---------------------------------------------------------------------------

  function automatic longint absv(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // tan(pi/2n) in Q.16, zero for orders not in use
  function automatic longint tan_half_step(input logic [2:0] ord);
    case (ord)
      ORD_2:   return TAN_PI_4;
      ORD_3:   return TAN_PI_6;
      ORD_4:   return TAN_PI_8;
      ORD_6:   return TAN_PI_12;
      default: return 0;
    endcase
  endfunction

  function automatic bit unit_within(input longint a);
    return absv(a) <= UNIT_Q32;
  endfunction

  // |wa*a + wb*b| <= 1 in Q.48
  function automatic bit plane_within(input longint wa, input longint a,
                                      input longint wb, input longint b);
    return absv(wa * a + wb * b) <= UNIT_Q48;
  endfunction

  function automatic bit zone_inside(input logic [2:0] cls, input logic [2:0] ord,
                                     input logic signed [17:0] ax,
                                     input logic signed [17:0] ay,
                                     input logic signed [17:0] az,
                                     input logic [23:0] len, input bit infinite);
    longint l, rx, ry, rz, zlim, m;
    bit     order_ok, ok;
    l        = longint'(len);
    rx       = longint'(ax) * l;
    ry       = longint'(ay) * l;
    rz       = longint'(az) * l;
    order_ok = (ord == ORD_2) || (ord == ORD_3) || (ord == ORD_4) || (ord == ORD_6);
    zlim     = tan_half_step(ord) <<< 16;
    case (cls)
      CLS_ANORTHIC: ok = 1'b1;
      CLS_CYCLIC: begin
        if (!order_ok) ok = 1'b0;
        else if (infinite) ok = (az == 0);
        else ok = absv(rz) <= zlim;
      end
      CLS_DIHEDRAL: begin
        ok = !infinite && (absv(rz) <= zlim);
        case (ord)
          ORD_2: ok = ok && unit_within(rx) && unit_within(ry);
          ORD_3: ok = ok && plane_within(ROOT3_HALF, rx, HALF_Q16, ry) &&
                      plane_within(ROOT3_HALF, rx, -HALF_Q16, ry) && unit_within(ry);
          ORD_4: ok = ok && unit_within(rx) && unit_within(ry) &&
                      plane_within(ROOT2_HALF, rx, ROOT2_HALF, ry) &&
                      plane_within(ROOT2_HALF, rx, -ROOT2_HALF, ry);
          ORD_6: ok = ok && plane_within(HALF_Q16, rx, ROOT3_HALF, ry) &&
                      plane_within(ROOT3_HALF, rx, HALF_Q16, ry) &&
                      plane_within(ROOT3_HALF, rx, -HALF_Q16, ry) &&
                      plane_within(HALF_Q16, rx, -ROOT3_HALF, ry) &&
                      unit_within(ry) && unit_within(rx);
          default: ok = 1'b0;
        endcase
      end
      CLS_TETRA, CLS_OCTA: begin
        ok = !infinite && (absv(rx) + absv(ry) + absv(rz) <= UNIT_Q32);
        m  = absv(rx);
        if (absv(ry) > m) m = absv(ry);
        if (absv(rz) > m) m = absv(rz);
        // octahedral also caps the largest component at tan(pi/8)
        if (cls == CLS_OCTA && m > (TAN_PI_8 <<< 16)) ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_word(input logic signed [17:0] ax, input logic signed [17:0] ay,
                           input logic signed [17:0] az, input logic [23:0] len,
                           input bit infinite, input bit inside_exp);
    in_valid_i        <= 1'b1;
    axis_x_i          <= ax;
    axis_y_i          <= ay;
    axis_z_i          <= az;
    vector_length_i   <= len;
    length_infinite_i <= infinite;
    do @(posedge clk_i); while (in_stall_o);
    queue_expected(inside_exp);
    words_sent++;
  endtask

  task automatic wait_drained();
    while (inside_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, written back to back once the pipe is empty
  task automatic set_zone_config(input logic [2:0] cls, input logic [2:0] ord);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CLASS;
    cfg_wdata_i <= cls;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ORDER;
    cfg_wdata_i <= ord;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_cls = cls;
    cur_ord = ord;
  endtask

  // component near one of the plane constants, random sign
  function automatic int boundary_value();
    int base;
    case ($urandom_range(0, 7))
      0:       base = 0;
      1:       base = int'(TAN_PI_12);
      2:       base = int'(TAN_PI_8);
      3:       base = int'(HALF_Q16);
      4:       base = int'(TAN_PI_6);
      5:       base = int'(ROOT2_HALF);
      6:       base = int'(ROOT3_HALF);
      default: base = int'(UNIT_Q16);
    endcase
    base = base + int'($urandom_range(0, 4)) - 2;
    return $urandom_range(0, 1) ? -base : base;
  endfunction

  task automatic send_random_word();
    int          c[3];
    logic [23:0] len;
    bit          infinite;
    int          mode;
    mode     = $urandom_range(0, 9);
    infinite = ($urandom_range(0, 15) == 0);
    if (mode == 0) begin
      // raw codes, every bit free
      foreach (c[i]) c[i] = int'($urandom);
      len      = 24'($urandom);
      infinite = 1'($urandom_range(0, 1));
    end else if (mode <= 3) begin
      // unit length, components near the plane constants
      foreach (c[i]) c[i] = boundary_value();
      len = 24'(int'(LENGTH_ONE) + int'($urandom_range(0, 4)) - 2);
    end else if (mode == 4) begin
      // components summing to about one: the cube face
      c[0] = $urandom_range(0, 65536);
      c[1] = $urandom_range(0, 65536 - c[0]);
      c[2] = 65536 - c[0] - c[1] + int'($urandom_range(0, 4)) - 2;
      foreach (c[i]) if ($urandom_range(0, 1)) c[i] = -c[i];
      len = LENGTH_ONE;
    end else begin
      // unit-range axis, moderate length
      foreach (c[i]) c[i] = int'($urandom_range(0, 131072)) - 65536;
      len = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 24'h40000))
                                        : 24'($urandom_range(0, 24'h20000));
    end
    if (infinite && $urandom_range(0, 1)) c[2] = 0;
    send_word(18'(c[0]), 18'(c[1]), 18'(c[2]), len, infinite,
              zone_inside(cur_cls, cur_ord, 18'(c[0]), 18'(c[1]), 18'(c[2]), len, infinite));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    zone_case_t row;
    logic [2:0] ph_cls, ph_ord;
    int         n_words;

    //                 class         order        x              y              z
    //                 length        inf   typed  inside
    add_row('{CLS_ANORTHIC, ORD_2, AXIS_MIN_CODE, AXIS_MAX_CODE, 18'sd0,
              LENGTH_MAX, 1'b1, 1'b1, 1'b1});
    add_row('{CLS_ANORTHIC, ORD_2, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b0, 1'b1, 1'b1});
    // cyclic, infinite: only the z component decides
    add_row('{CLS_CYCLIC, ORD_2, AXIS_ONE, 18'sd0, 18'sd0,
              LENGTH_MAX, 1'b1, 1'b1, 1'b1});
    add_row('{CLS_CYCLIC, ORD_2, 18'sd0, 18'sd0, 18'sd1,
              24'd0, 1'b1, 1'b1, 1'b0});
    // cyclic, finite: z on and just past the bound
    add_row('{CLS_CYCLIC, ORD_2, 18'sd0, 18'sd0, AXIS_ONE,
              LENGTH_ONE, 1'b0, 1'b1, 1'b1});
    add_row('{CLS_CYCLIC, ORD_2, 18'sd0, 18'sd0, -AXIS_ONE,
              LENGTH_ONE + 24'd1, 1'b0, 1'b1, 1'b0});
    add_row('{CLS_CYCLIC, ORD_6, 18'sd0, 18'sd0, 18'sd17560,
              LENGTH_ONE, 1'b0, 1'b1, 1'b1});
    add_row('{CLS_CYCLIC, ORD_6, 18'sd0, 18'sd0, 18'sd17561,
              LENGTH_ONE, 1'b0, 1'b1, 1'b0});
    // unknown orders are outside, infinite too
    add_row('{CLS_CYCLIC, ORD_SPARE5, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b1, 1'b1, 1'b0});
    add_row('{CLS_CYCLIC, ORD_SPARE0, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b0, 1'b1, 1'b0});
    add_row('{CLS_DIHEDRAL, ORD_2, AXIS_ONE, -AXIS_ONE, 18'sd0,
              LENGTH_ONE, 1'b0, 1'b1, 1'b1});
    add_row('{CLS_DIHEDRAL, ORD_2, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b1, 1'b1, 1'b0});
    add_row('{CLS_DIHEDRAL, ORD_3, 18'sd30000, 18'sd20000, 18'sd10000,
              LENGTH_ONE, 1'b0, 1'b0, 1'b0});
    add_row('{CLS_DIHEDRAL, ORD_4, 18'sd46341, 18'sd46341, 18'sd0,
              LENGTH_ONE, 1'b0, 1'b0, 1'b0});
    add_row('{CLS_DIHEDRAL, ORD_6, 18'sd56756, 18'sd32768, 18'sd0,
              LENGTH_ONE, 1'b0, 1'b0, 1'b0});
    add_row('{CLS_DIHEDRAL, ORD_SPARE7, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b0, 1'b1, 1'b0});
    // tetrahedral: on and past the cube face, infinite
    add_row('{CLS_TETRA, ORD_2, AXIS_ONE, 18'sd0, 18'sd0,
              LENGTH_ONE, 1'b0, 1'b1, 1'b1});
    add_row('{CLS_TETRA, ORD_2, -AXIS_ONE, 18'sd1, 18'sd0,
              LENGTH_ONE, 1'b0, 1'b1, 1'b0});
    add_row('{CLS_TETRA, ORD_2, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b1, 1'b1, 1'b0});
    // octahedral: largest component on and past tan(pi/8)
    add_row('{CLS_OCTA, ORD_2, 18'sd27146, 18'sd0, 18'sd0,
              LENGTH_ONE, 1'b0, 1'b1, 1'b1});
    add_row('{CLS_OCTA, ORD_2, 18'sd0, -18'sd27147, 18'sd0,
              LENGTH_ONE, 1'b0, 1'b1, 1'b0});
    add_row('{CLS_OCTA, ORD_2, AXIS_MIN_CODE, AXIS_MIN_CODE, AXIS_MIN_CODE,
              LENGTH_MAX, 1'b0, 1'b1, 1'b0});
    // classes without a zone
    add_row('{CLS_SPARE5, ORD_2, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b0, 1'b1, 1'b0});
    add_row('{CLS_SPARE7, ORD_2, 18'sd0, 18'sd0, 18'sd0,
              24'd0, 1'b0, 1'b1, 1'b0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (rows[k]) begin
      row = rows[k];
      if (row.cls != cur_cls || row.ord != cur_ord) set_zone_config(row.cls, row.ord);
      pace_sender();
      send_word(row.ax, row.ay, row.az, row.len, row.infinite,
                row.typed_in ? row.typed_inside
                             : zone_inside(cur_cls, cur_ord, row.ax, row.ay, row.az,
                                           row.len, row.infinite));
    end

    // random phases: cyclic and dihedral through every order, then every class
    for (int p = 0; p < 24; p++) begin
      if (p < 16) begin
        ph_cls  = p[0] ? CLS_DIHEDRAL : CLS_CYCLIC;
        ph_ord  = 3'(p >> 1);
        n_words = (tan_half_step(ph_ord) != 0) ? 110 : 30;
      end else begin
        ph_cls  = 3'(p - 16);
        ph_ord  = 3'($urandom_range(0, 7));
        n_words = 90;
      end
      set_zone_config(ph_cls, ph_ord);
      repeat (n_words) begin
        pace_sender();
        send_random_word();
      end
    end

    in_valid_i <= 1'b0;
    while (inside_expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern, with one long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && words_sent >= HOLD_AFTER) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest expected word
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inside_expected_q.size() == 0) begin
        $error("inside_zone: no word pending, actual %0b", inside_zone_o);
        fail_count++;
      end else begin
        inside_want = inside_expected_q.pop_front();
        if (inside_zone_o !== inside_want) begin
          $error("inside_zone: expected %0b, actual %0b", inside_want, inside_zone_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
rtl/rfz_pkg.sv
rtl/rfz_scale.sv
rtl/rfz_plane.sv
rtl/rfz_decide.sv
rtl/rodrigues_fundamental_zone_test.sv
test/rodrigues_fundamental_zone_test_test.sv
